### rtl/crpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_pkg
// Shared types and constants of the controller report packet framer.
// ----------------------------------------------------------------------------
package crpf_pkg;

  localparam int unsigned FRAME_LEN  = 17;
  localparam int unsigned SLIDER_W   = 32;
  localparam int unsigned BEAM_W     = 6;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'h55;

  // One frame byte with its end-of-frame mark
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } fbyte_t;

  // Contents of one shift cell
  typedef struct packed {
    logic   valid;
    fbyte_t fb;
  } cell_t;

  // Per-cycle control shared by every cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Whole frame, element 0 is transmitted first
  typedef fbyte_t [FRAME_LEN-1:0] frame_t;

endpackage

### rtl/crpf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_in_if
// Snapshot channel: one controller snapshot per transfer.
// ----------------------------------------------------------------------------
interface crpf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] slider_touch;
  logic [5:0]  beam_states;
  logic        test_pressed;
  logic        service_pressed;
  logic        coin_pressed;

  modport source (
    output valid, slider_touch, beam_states, test_pressed, service_pressed, coin_pressed,
    input  ready
  );
  modport sink (
    input  valid, slider_touch, beam_states, test_pressed, service_pressed, coin_pressed,
    output ready
  );
endinterface

### rtl/crpf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_out_if
// Byte channel: one frame byte per transfer, with end-of-frame mark.
// ----------------------------------------------------------------------------
interface crpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input  valid, frame_byte, frame_end, output ready);
endinterface

### rtl/crpf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_cell
// One byte cell of the output shift chain: parallel load or shift from the
// upstream neighbor.
// ----------------------------------------------------------------------------
module crpf_cell
  import crpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  fbyte_t     load_i,
  input  cell_t      nbr_i,
  output cell_t      cell_o
);

  logic   valid_q, valid_d;
  fbyte_t fb_q, fb_d;

  // load wins over shift
  always_comb begin
    valid_d = valid_q;
    fb_d    = fb_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
      fb_d    = load_i;
    end else if (ctrl_i.shift) begin
      valid_d = nbr_i.valid;
      fb_d    = nbr_i.fb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fb_q <= fb_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.fb    = fb_q;

endmodule

### rtl/crpf_frame_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_frame_build
// Lays out one frame from a snapshot and owns the sequence counter.
// ----------------------------------------------------------------------------
module crpf_frame_build
  import crpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [SLIDER_W-1:0] slider_i,
  input  logic [BEAM_W-1:0]   beams_i,
  input  logic                test_i,
  input  logic                service_i,
  input  logic                coin_i,
  output frame_t              frame_o
);

  logic [BYTE_W-1:0] seq_q, seq_d;
  logic [BYTE_W-1:0] sum;

  // sequence number advances once per accepted snapshot
  assign seq_d = accept_i ? seq_q + 8'd1 : seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_d;
    end
  end

  // checksum: flag bytes only touch bit 0
  always_comb begin
    sum    = seq_q ^ slider_i[7:0] ^ slider_i[15:8] ^ slider_i[23:16] ^ slider_i[31:24];
    sum[0] = sum[0] ^ (^beams_i) ^ test_i ^ service_i ^ coin_i;
  end

  // frame layout in transmission order
  always_comb begin
    frame_o[0] = '{data: SYNC_A, last: 1'b0};
    frame_o[1] = '{data: SYNC_B, last: 1'b0};
    frame_o[2] = '{data: seq_q,  last: 1'b0};
    for (int k = 0; k < 4; k++) begin
      frame_o[3+k] = '{data: slider_i[8*k +: 8], last: 1'b0};
    end
    for (int k = 0; k < BEAM_W; k++) begin
      frame_o[7+k] = '{data: {7'd0, beams_i[k]}, last: 1'b0};
    end
    frame_o[13] = '{data: {7'd0, test_i},    last: 1'b0};
    frame_o[14] = '{data: {7'd0, service_i}, last: 1'b0};
    frame_o[15] = '{data: {7'd0, coin_i},    last: 1'b0};
    frame_o[16] = '{data: sum,               last: 1'b1};
  end

endmodule

### rtl/controller_report_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controller_report_packet_framer
// Turns each controller snapshot into a 17-byte report frame on a byte channel.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  snap_i   | in  | slider_touch, beam_states, 3 button bits | valid/ready
//  frame_o  | out | frame_byte, frame_end                    | valid/ready
//
// A snapshot loads all 17 cells of the shift chain at once; cell 0 drives the
// byte channel and the chain shifts one cell per byte transfer. The next
// snapshot is taken in the cycle the checksum byte transfers, so frames follow
// one another without gaps while the byte channel does not stall.
// Reset clears the cell valid bits and the sequence counter.
// A stall on the byte channel holds the chain; snapshots wait for it.
// ----------------------------------------------------------------------------
module controller_report_packet_framer
  import crpf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  crpf_in_if.sink    snap_i,
  crpf_out_if.source frame_o
);

  frame_t     frame;
  cell_ctrl_t ctrl;
  cell_t      cells [FRAME_LEN+1];
  logic       advance;
  logic       accept;

  // chain moves whenever its head is empty or being transferred
  assign advance = !cells[0].valid || frame_o.ready;
  // take a snapshot once only the head remains and it is leaving
  assign snap_i.ready = !cells[1].valid && advance;
  assign accept       = snap_i.valid && snap_i.ready;

  assign ctrl.load  = accept;
  assign ctrl.shift = advance;

  crpf_frame_build u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .slider_i  (snap_i.slider_touch),
    .beams_i   (snap_i.beam_states),
    .test_i    (snap_i.test_pressed),
    .service_i (snap_i.service_pressed),
    .coin_i    (snap_i.coin_pressed),
    .frame_o   (frame)
  );

  // empty filler beyond the top cell
  assign cells[FRAME_LEN] = '0;

  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
    crpf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (frame[k]),
      .nbr_i  (cells[k+1]),
      .cell_o (cells[k])
    );
  end

  assign frame_o.valid      = cells[0].valid;
  assign frame_o.frame_byte = cells[0].fb.data;
  assign frame_o.frame_end  = cells[0].fb.last;

endmodule
